/* hw/rtl/pibe_pkg.sv */
package pibe_pkg;

    localparam int XLEN     = 32;
    localparam int IDX_W    = 5;
    localparam int CR0_W    = 4;
    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = $clog2(Q_DEPTH);

    // Result status codes.
    typedef enum logic [2:0] {
        ST_EXEC    = 3'd0,
        ST_NOP     = 3'd1,
        ST_INTERP  = 3'd2,
        ST_MEM     = 3'd3,
        ST_ILLEGAL = 3'd4
    } t_status;

    // Primary opcodes that are decoded by name.
    localparam logic [5:0] OP_GRP4   = 6'd4;
    localparam logic [5:0] OP_ADDI   = 6'd14;
    localparam logic [5:0] OP_ADDIS  = 6'd15;
    localparam logic [5:0] OP_BC     = 6'd16;
    localparam logic [5:0] OP_B      = 6'd18;
    localparam logic [5:0] OP_GRP19  = 6'd19;
    localparam logic [5:0] OP_RLWIMI = 6'd20;
    localparam logic [5:0] OP_RLWINM = 6'd21;
    localparam logic [5:0] OP_ORI    = 6'd24;
    localparam logic [5:0] OP_ORIS   = 6'd25;
    localparam logic [5:0] OP_XORI   = 6'd26;
    localparam logic [5:0] OP_XORIS  = 6'd27;
    localparam logic [5:0] OP_ANDI   = 6'd28;
    localparam logic [5:0] OP_ANDIS  = 6'd29;
    localparam logic [5:0] OP_GRP31  = 6'd31;
    localparam logic [5:0] OP_GRP59  = 6'd59;
    localparam logic [5:0] OP_GRP63  = 6'd63;

    // Extended opcodes with a dedicated meaning.
    localparam logic [9:0] XO_ADD      = 10'd266;
    localparam logic [9:0] XO_GRP4_NOP = 10'd1014;
    localparam logic [9:0] XO_ISYNC    = 10'd150;

    // Operation carried from the front to the back.
    typedef enum logic [3:0] {
        K_NONE   = 4'd0,
        K_ADDI   = 4'd1,
        K_ADDIS  = 4'd2,
        K_ORI    = 4'd3,
        K_ORIS   = 4'd4,
        K_XORI   = 4'd5,
        K_XORIS  = 4'd6,
        K_ANDI   = 4'd7,
        K_ANDIS  = 4'd8,
        K_RLWINM = 4'd9,
        K_RLWIMI = 4'd10,
        K_ADD    = 4'd11,
        K_B      = 4'd12,
        K_BC     = 4'd13
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        t_status           status;
        logic [IDX_W-1:0]  src_a;
        logic [IDX_W-1:0]  src_b;
        logic              a_zero;
        logic [XLEN-1:0]   word;
        logic [XLEN-1:0]   addr;
    } t_dec;

    // Status of every opcode that is not executed by the core.
    function automatic t_status f_classify(logic [5:0] op, logic [9:0] x10, logic [4:0] x5);
        t_status st;
        st = ST_ILLEGAL;
        unique case (op)
            OP_GRP4: begin
                if (x10 inside {10'd18, 10'd20, 10'd21, 10'd40, 10'd72, 10'd136, 10'd264,
                                10'd528, 10'd560, 10'd592, 10'd624}) begin
                    st = ST_INTERP;
                end else if (x10 == XO_GRP4_NOP) begin
                    st = ST_NOP;
                end else if (x5 inside {5'd10, 5'd11, 5'd12, 5'd13, 5'd25, 5'd28, 5'd29,
                                        5'd30, 5'd31}) begin
                    st = ST_INTERP;
                end
            end
            6'd7, 6'd8, 6'd10, 6'd11, 6'd12, 6'd13, 6'd17, 6'd36, 6'd37, 6'd38, 6'd39,
            6'd44, 6'd45, 6'd46, 6'd47, 6'd48, 6'd49, 6'd50, 6'd51, 6'd52, 6'd53, 6'd54,
            6'd55, 6'd56, 6'd60: begin
                st = ST_INTERP;
            end
            OP_GRP19: begin
                if (x10 inside {10'd16, 10'd50, 10'd193, 10'd528}) begin
                    st = ST_INTERP;
                end else if (x10 == XO_ISYNC) begin
                    st = ST_NOP;
                end
            end
            OP_GRP31: begin
                if (x10 inside {10'd54, 10'd86, 10'd470, 10'd598, 10'd854}) begin
                    st = ST_NOP;
                end else if (x10 inside {10'd534, 10'd535, 10'd599, 10'd631, 10'd662,
                                         10'd663, 10'd695, 10'd727, 10'd983}) begin
                    st = ST_MEM;
                end else if (x10 inside {10'd0, 10'd8, 10'd10, 10'd11, 10'd19, 10'd20,
                        10'd23, 10'd24, 10'd26, 10'd28, 10'd32, 10'd40, 10'd55, 10'd60,
                        10'd75, 10'd83, 10'd87, 10'd104, 10'd119, 10'd124, 10'd136,
                        10'd138, 10'd144, 10'd146, 10'd150, 10'd151, 10'd183, 10'd200,
                        10'd202, 10'd210, 10'd215, 10'd235, 10'd247, 10'd279, 10'd306,
                        10'd311, 10'd316, 10'd339, 10'd343, 10'd371, 10'd375, 10'd407,
                        10'd439, 10'd444, 10'd459, 10'd467, 10'd491, 10'd536, 10'd567,
                        10'd595, 10'd759, 10'd792, 10'd824, 10'd922, 10'd954, 10'd982,
                        10'd1014}) begin
                    st = ST_INTERP;
                end
            end
            6'd32, 6'd33, 6'd34, 6'd35, 6'd40, 6'd41, 6'd42, 6'd43: begin
                st = ST_MEM;
            end
            OP_GRP59: begin
                if (x5 inside {5'd18, 5'd20, 5'd21, 5'd25, 5'd28, 5'd29, 5'd30, 5'd31}) begin
                    st = ST_INTERP;
                end
            end
            OP_GRP63: begin
                if (x10 inside {10'd0, 10'd12, 10'd15, 10'd18, 10'd20, 10'd21, 10'd26,
                                10'd40, 10'd72, 10'd264, 10'd583, 10'd711}) begin
                    st = ST_INTERP;
                end else if (x5 inside {5'd23, 5'd25, 5'd28, 5'd29, 5'd30, 5'd31}) begin
                    st = ST_INTERP;
                end
            end
            default: begin
                st = ST_ILLEGAL;
            end
        endcase
        return st;
    endfunction

endpackage

/* hw/rtl/pibe_instr_if.sv */
interface pibe_instr_if
    import pibe_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [XLEN-1:0] instr_word;
    logic [XLEN-1:0] instr_addr;

    modport source (output valid, output instr_word, output instr_addr, input ready);
    modport sink   (input valid, input instr_word, input instr_addr, output ready);
endinterface

/* hw/rtl/pibe_result_if.sv */
interface pibe_result_if
    import pibe_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [XLEN-1:0]  next_pc;
    logic [2:0]       status;
    logic             reg_written;
    logic [IDX_W-1:0] dest_index;
    logic [XLEN-1:0]  dest_value;
    logic [CR0_W-1:0] cr0_bits;

    modport source (output valid, output next_pc, output status, output reg_written,
                    output dest_index, output dest_value, output cr0_bits, input ready);
    modport sink   (input valid, input next_pc, input status, input reg_written,
                    input dest_index, input dest_value, input cr0_bits, output ready);
endinterface

/* hw/rtl/pibe_front.sv */
// Decodes the incoming instruction word into an operation, its register
// sources and, for opcodes that are not executed, their status.
module pibe_front
    import pibe_pkg::*;
(
    pibe_instr_if.sink i_instr,
    input  logic       i_q_full,
    output logic       o_push,
    output t_dec       o_push_dec
);

    logic [5:0]       op;
    logic [9:0]       x10;
    logic [4:0]       x5;
    logic [IDX_W-1:0] fld_d;
    logic [IDX_W-1:0] fld_a;
    logic [IDX_W-1:0] fld_b;

    assign op    = i_instr.instr_word[31:26];
    assign fld_d = i_instr.instr_word[25:21];
    assign fld_a = i_instr.instr_word[20:16];
    assign fld_b = i_instr.instr_word[15:11];
    assign x10   = i_instr.instr_word[10:1];
    assign x5    = i_instr.instr_word[5:1];

    assign i_instr.ready = !i_q_full;
    assign o_push        = i_instr.valid && !i_q_full;

    always_comb begin
        o_push_dec.kind   = K_NONE;
        o_push_dec.status = ST_EXEC;
        o_push_dec.src_a  = fld_d;
        o_push_dec.src_b  = fld_a;
        o_push_dec.a_zero = 1'b0;
        o_push_dec.word   = i_instr.instr_word;
        o_push_dec.addr   = i_instr.instr_addr;
        unique case (op)
            OP_ADDI, OP_ADDIS: begin
                o_push_dec.kind   = (op == OP_ADDI) ? K_ADDI : K_ADDIS;
                o_push_dec.src_a  = fld_a;
                o_push_dec.a_zero = (fld_a == '0);
            end
            OP_ORI:    o_push_dec.kind = K_ORI;
            OP_ORIS:   o_push_dec.kind = K_ORIS;
            OP_XORI:   o_push_dec.kind = K_XORI;
            OP_XORIS:  o_push_dec.kind = K_XORIS;
            OP_ANDI:   o_push_dec.kind = K_ANDI;
            OP_ANDIS:  o_push_dec.kind = K_ANDIS;
            OP_RLWINM: o_push_dec.kind = K_RLWINM;
            OP_RLWIMI: o_push_dec.kind = K_RLWIMI;
            OP_B:      o_push_dec.kind = K_B;
            OP_BC:     o_push_dec.kind = K_BC;
            OP_GRP31: begin
                if (x10 == XO_ADD) begin
                    o_push_dec.kind  = K_ADD;
                    o_push_dec.src_a = fld_a;
                    o_push_dec.src_b = fld_b;
                end else begin
                    o_push_dec.status = f_classify(op, x10, x5);
                end
            end
            default: begin
                o_push_dec.status = f_classify(op, x10, x5);
            end
        endcase
    end

endmodule

/* hw/rtl/pibe_queue.sv */
// Small FIFO of decoded items between the front and the back.
module pibe_queue
    import pibe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_dec i_push_dec,
    output logic o_full,
    output logic o_vld,
    output t_dec o_head,
    input  logic i_pop
);

    t_dec            r_slot [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;
    logic [Q_AW:0]   n_count;

    assign o_full = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_vld  = (r_count != '0);
    assign o_head = r_slot[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !(i_pop && o_vld)) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop && o_vld) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop && o_vld) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_dec;
        end
    end

endmodule

/* hw/rtl/pibe_back.sv */
// Register read stage followed by the execute step, which commits the
// architectural state and fills the output register.
module pibe_back
    import pibe_pkg::*;
#(
    parameter int NUM_GPRS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_vld,
    input  t_dec          i_q_head,
    output logic          o_q_pop,
    pibe_result_if.source o_result
);

    localparam int GPR_AW = $clog2(NUM_GPRS);

    // General registers: memory plus one valid bit per entry; an entry that
    // was never written since reset reads as zero.
    logic [XLEN-1:0]     r_gpr_mem [NUM_GPRS];
    logic [NUM_GPRS-1:0] r_gpr_vld;

    logic [XLEN-1:0] r_cr;
    logic [XLEN-1:0] r_lr;
    logic [XLEN-1:0] r_ctr;

    // Read stage.
    logic            r_rd_vld;
    t_dec            r_rd_dec;
    logic [XLEN-1:0] r_rd_a_data;
    logic [XLEN-1:0] r_rd_b_data;
    logic            r_rd_a_vld;
    logic            r_rd_b_vld;

    // Most recent register write, forwarded past the memory read.
    logic              r_wb_en;
    logic [GPR_AW-1:0] r_wb_idx;
    logic [XLEN-1:0]   r_wb_val;

    // Output register.
    logic             r_out_vld;
    logic [XLEN-1:0]  r_out_npc;
    t_status          r_out_status;
    logic             r_out_wr;
    logic [IDX_W-1:0] r_out_idx;
    logic [XLEN-1:0]  r_out_val;
    logic [CR0_W-1:0] r_out_cr0;

    logic ex_fire;
    logic rd_ready;

    logic [XLEN-1:0]   op_a;
    logic [XLEN-1:0]   op_b;
    logic [XLEN-1:0]   a_raw;
    logic [XLEN-1:0]   w;
    logic [XLEN-1:0]   seq_pc;
    logic [XLEN-1:0]   simm;
    logic [XLEN-1:0]   uimm;
    logic [XLEN-1:0]   uimm_hi;
    logic [XLEN-1:0]   rot_mask;
    logic [2*XLEN-1:0] rot_dbl;
    logic [XLEN-1:0]   rot;
    logic [XLEN-1:0]   br_off;
    logic [XLEN-1:0]   br_tgt;
    logic [XLEN-1:0]   ctr_m1;
    logic [4:0]        bo;
    logic [4:0]        bi;
    logic              take;

    logic             ex_wr;
    logic             ex_rec;
    logic [IDX_W-1:0] ex_idx;
    logic [XLEN-1:0]  ex_val;
    logic [XLEN-1:0]  ex_npc;
    logic             ex_lr_wr;
    logic             ex_ctr_wr;
    logic [XLEN-1:0]  n_cr;

    function automatic logic [XLEN-1:0] f_mask(logic [4:0] mb, logic [4:0] me);
        logic [XLEN-1:0] m;
        logic [4:0]      pos;
        for (int j = 0; j < XLEN; j++) begin
            pos = 5'(XLEN - 1 - j);
            if (mb <= me) begin
                m[j] = (pos >= mb) && (pos <= me);
            end else begin
                m[j] = (pos >= mb) || (pos <= me);
            end
        end
        return m;
    endfunction

    assign ex_fire  = r_rd_vld && (!r_out_vld || o_result.ready);
    assign rd_ready = !r_rd_vld || ex_fire;
    assign o_q_pop  = i_q_vld && rd_ready;

    // Operand selection with forwarding of the write made at the load edge.
    always_comb begin
        if (r_wb_en && r_wb_idx == r_rd_dec.src_a[GPR_AW-1:0]) begin
            a_raw = r_wb_val;
        end else begin
            a_raw = r_rd_a_vld ? r_rd_a_data : '0;
        end
        op_a = r_rd_dec.a_zero ? '0 : a_raw;
        if (r_wb_en && r_wb_idx == r_rd_dec.src_b[GPR_AW-1:0]) begin
            op_b = r_wb_val;
        end else begin
            op_b = r_rd_b_vld ? r_rd_b_data : '0;
        end
    end

    assign w        = r_rd_dec.word;
    assign seq_pc   = r_rd_dec.addr + XLEN'(4);
    assign uimm     = {16'b0, w[15:0]};
    assign simm     = {{16{w[15]}}, w[15:0]};
    assign uimm_hi  = {w[15:0], 16'b0};
    assign rot_mask = f_mask(w[10:6], w[5:1]);
    assign rot_dbl  = {op_a, op_a} << w[15:11];
    assign rot      = rot_dbl[2*XLEN-1:XLEN];
    assign bo       = w[25:21];
    assign bi       = w[20:16];
    assign ctr_m1   = r_ctr - 1'b1;
    // Conditional branches carry a 14-bit displacement, b a 24-bit one.
    assign br_off   = (r_rd_dec.kind == K_BC) ? {{16{w[15]}}, w[15:2], 2'b00}
                                              : {{6{w[25]}}, w[25:2], 2'b00};
    assign br_tgt   = w[1] ? br_off : r_rd_dec.addr + br_off;

    always_comb begin
        ex_wr     = 1'b0;
        ex_rec    = 1'b0;
        ex_idx    = w[20:16];
        ex_val    = '0;
        ex_npc    = seq_pc;
        ex_lr_wr  = 1'b0;
        ex_ctr_wr = 1'b0;
        take      = 1'b0;
        unique case (r_rd_dec.kind)
            K_ADDI: begin
                ex_wr = 1'b1; ex_idx = w[25:21]; ex_val = op_a + simm;
            end
            K_ADDIS: begin
                ex_wr = 1'b1; ex_idx = w[25:21]; ex_val = op_a + uimm_hi;
            end
            K_ORI:   begin ex_wr = 1'b1; ex_val = op_a | uimm; end
            K_ORIS:  begin ex_wr = 1'b1; ex_val = op_a | uimm_hi; end
            K_XORI:  begin ex_wr = 1'b1; ex_val = op_a ^ uimm; end
            K_XORIS: begin ex_wr = 1'b1; ex_val = op_a ^ uimm_hi; end
            K_ANDI:  begin ex_wr = 1'b1; ex_rec = 1'b1; ex_val = op_a & uimm; end
            K_ANDIS: begin ex_wr = 1'b1; ex_rec = 1'b1; ex_val = op_a & uimm_hi; end
            K_RLWINM: begin
                ex_wr = 1'b1; ex_rec = w[0]; ex_val = rot & rot_mask;
            end
            K_RLWIMI: begin
                ex_wr  = 1'b1;
                ex_rec = w[0];
                ex_val = (rot & rot_mask) | (op_b & ~rot_mask);
            end
            K_ADD: begin
                ex_wr = 1'b1; ex_rec = w[0]; ex_idx = w[25:21]; ex_val = op_a + op_b;
            end
            K_B: begin
                ex_lr_wr = w[0];
                ex_npc   = br_tgt;
            end
            K_BC: begin
                ex_lr_wr  = w[0];
                ex_ctr_wr = !bo[2];
                take      = (bo[2] || ((ctr_m1 == '0) == bo[1]))
                         && (bo[4] || (r_cr[~bi] == bo[3]));
                ex_npc    = take ? br_tgt : seq_pc;
            end
            default: begin
                ex_wr = 1'b0;
            end
        endcase
    end

    // CR0 from the signed result: LT, GT, EQ; SO is kept.
    always_comb begin
        n_cr = r_cr;
        if (ex_wr && ex_rec) begin
            n_cr[31] = ex_val[XLEN-1];
            n_cr[30] = !ex_val[XLEN-1] && (ex_val != '0);
            n_cr[29] = (ex_val == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_wb_en   <= 1'b0;
            r_gpr_vld <= '0;
            r_cr      <= '0;
            r_lr      <= '0;
            r_ctr     <= '0;
        end else begin
            if (rd_ready) begin
                r_rd_vld <= i_q_vld;
            end
            if (ex_fire) begin
                r_out_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
            if (ex_fire) begin
                r_cr <= n_cr;
                if (ex_wr) begin
                    r_wb_en                           <= 1'b1;
                    r_gpr_vld[ex_idx[GPR_AW-1:0]] <= 1'b1;
                end
                if (ex_lr_wr) begin
                    r_lr <= seq_pc;
                end
                if (ex_ctr_wr) begin
                    r_ctr <= ctr_m1;
                end
            end
        end
    end

    // Register file memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (ex_fire && ex_wr) begin
            r_gpr_mem[ex_idx[GPR_AW-1:0]] <= ex_val;
        end
        if (o_q_pop) begin
            r_rd_a_data <= r_gpr_mem[i_q_head.src_a[GPR_AW-1:0]];
            r_rd_b_data <= r_gpr_mem[i_q_head.src_b[GPR_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rd_dec   <= i_q_head;
            r_rd_a_vld <= r_gpr_vld[i_q_head.src_a[GPR_AW-1:0]];
            r_rd_b_vld <= r_gpr_vld[i_q_head.src_b[GPR_AW-1:0]];
        end
        if (ex_fire && ex_wr) begin
            r_wb_idx <= ex_idx[GPR_AW-1:0];
            r_wb_val <= ex_val;
        end
        if (ex_fire) begin
            r_out_npc    <= ex_npc;
            r_out_status <= r_rd_dec.status;
            r_out_wr     <= ex_wr;
            r_out_idx    <= ex_wr ? ex_idx : '0;
            r_out_val    <= ex_wr ? ex_val : '0;
            r_out_cr0    <= n_cr[XLEN-1:XLEN-CR0_W];
        end
    end

    assign o_result.valid       = r_out_vld;
    assign o_result.next_pc     = r_out_npc;
    assign o_result.status      = r_out_status;
    assign o_result.reg_written = r_out_wr;
    assign o_result.dest_index  = r_out_idx;
    assign o_result.dest_value  = r_out_val;
    assign o_result.cr0_bits    = r_out_cr0;

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_wr) |-> (r_out_idx == '0 && r_out_val == '0))
        else $error("result without register write carries a nonzero destination");

    a_write_only_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_wr) |-> (r_out_status == ST_EXEC))
        else $error("register write reported on an item that was not executed");

    a_write_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ex_fire && ex_wr) |=> r_gpr_vld[$past(ex_idx[GPR_AW-1:0])])
        else $error("register valid bit not set after a write");

    a_rd_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_vld && !ex_fire) |=> (r_rd_vld && $stable(r_rd_dec)))
        else $error("read stage item changed while the execute step was stalled");

endmodule

/* hw/rtl/ppc_integer_branch_execute_core.sv */
// Integer and branch execute core for 32-bit PowerPC instruction words.
// The i_instr channel carries one instruction word with its address per
// item; the o_result channel returns one item per instruction: next PC,
// status, the general register write (index and value) and CR0 after the
// instruction. Both channels use valid/ready and move an item at a rising
// clock edge where both are high.
// The front decodes and classifies each item and places it in a four-entry
// queue. The back reads the register file (registered read, with the last
// write forwarded), executes and commits GPR, CR, LR and CTR, and loads the
// output register. An item passes the queue and the read stage before its
// result is offered; one item per cycle is sustained while ready is high,
// set by the single execute step that carries the register dependency.
// Synchronous reset (i_rst_n low) empties the queue and the pipeline and
// clears CR, LR, CTR and all register valid bits, so every GPR reads as
// zero; no clearing pass is needed. When the receiver holds ready low the
// output register keeps its item, the back stops, and the queue absorbs up
// to four more items before i_instr.ready falls.
module ppc_integer_branch_execute_core
    import pibe_pkg::*;
#(
    parameter int NUM_GPRS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pibe_instr_if.sink    i_instr,
    pibe_result_if.source o_result
);

    logic push;
    t_dec push_dec;
    logic q_full;
    logic q_vld;
    t_dec q_head;
    logic q_pop;

    // Decode and classification of the incoming item.
    pibe_front u_front (
        .i_instr    (i_instr),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_push_dec (push_dec)
    );

    // Decouples acceptance from execution.
    pibe_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_dec (push_dec),
        .o_full     (q_full),
        .o_vld      (q_vld),
        .o_head     (q_head),
        .i_pop      (q_pop)
    );

    // Register read, execute and architectural state.
    pibe_back #(
        .NUM_GPRS (NUM_GPRS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_vld  (q_vld),
        .i_q_head (q_head),
        .o_q_pop  (q_pop),
        .o_result (o_result)
    );

endmodule

/* bench/pibe_exec_checker.sv */
module pibe_exec_checker
    import pibe_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    pibe_instr_if  instr_ch,
    pibe_result_if result_ch,
    output int     o_mismatches,
    output int     o_results_due
);

    typedef struct packed {
        logic [XLEN-1:0]  next_pc;
        t_status          status;
        logic             reg_written;
        logic [IDX_W-1:0] dest_index;
        logic [XLEN-1:0]  dest_value;
        logic [CR0_W-1:0] cr0_bits;
    } t_exec_result;

    // Architectural state as the core should hold it.
    logic [XLEN-1:0] gpr [32];
    logic [XLEN-1:0] cr;
    logic [XLEN-1:0] lr;
    logic [XLEN-1:0] ctr;

    t_exec_result results_due [$];
    t_exec_result due;
    int           results_seen;

    initial begin
        o_mismatches  = 0;
        o_results_due = 0;
        results_seen  = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        o_mismatches++;
        $display("mismatch: %s on result %0d, got %h, expected %h",
                 what, results_seen, got, want);
    endtask

    // Class of an opcode that the core does not execute.
    function automatic t_status classify_other(logic [5:0] op, logic [9:0] x10,
                                               logic [4:0] x5);
        t_status st;
        st = ST_ILLEGAL;
        case (op)
            OP_GRP4: begin
                case (x10)
                    18, 20, 21, 40, 72, 136, 264, 528, 560, 592, 624: st = ST_INTERP;
                    XO_GRP4_NOP: st = ST_NOP;
                    default: begin
                        case (x5)
                            10, 11, 12, 13, 25, 28, 29, 30, 31: st = ST_INTERP;
                            default: st = ST_ILLEGAL;
                        endcase
                    end
                endcase
            end
            OP_GRP19: begin
                case (x10)
                    16, 50, 193, 528: st = ST_INTERP;
                    XO_ISYNC: st = ST_NOP;
                    default: st = ST_ILLEGAL;
                endcase
            end
            OP_GRP31: begin
                case (x10)
                    54, 86, 470, 598, 854: st = ST_NOP;
                    534, 535, 599, 631, 662, 663, 695, 727, 983: st = ST_MEM;
                    0, 8, 10, 11, 19, 20, 23, 24, 26, 28, 32, 40, 55, 60, 75, 83, 87,
                    104, 119, 124, 136, 138, 144, 146, 150, 151, 183, 200, 202, 210,
                    215, 235, 247, 279, 306, 311, 316, 339, 343, 371, 375, 407, 439,
                    444, 459, 467, 491, 536, 567, 595, 759, 792, 824, 922, 954, 982,
                    1014: st = ST_INTERP;
                    default: st = ST_ILLEGAL;
                endcase
            end
            OP_GRP59: begin
                case (x5)
                    18, 20, 21, 25, 28, 29, 30, 31: st = ST_INTERP;
                    default: st = ST_ILLEGAL;
                endcase
            end
            OP_GRP63: begin
                case (x10)
                    0, 12, 15, 18, 20, 21, 26, 40, 72, 264, 583, 711: st = ST_INTERP;
                    default: begin
                        case (x5)
                            23, 25, 28, 29, 30, 31: st = ST_INTERP;
                            default: st = ST_ILLEGAL;
                        endcase
                    end
                endcase
            end
            7, 8, 10, 11, 12, 13, 17, 36, 37, 38, 39, 44, 45, 46, 47, 48, 49, 50,
            51, 52, 53, 54, 55, 56, 60: st = ST_INTERP;
            32, 33, 34, 35, 40, 41, 42, 43: st = ST_MEM;
            default: st = ST_ILLEGAL;
        endcase
        return st;
    endfunction

    function automatic logic [31:0] rot_left(logic [31:0] v, logic [4:0] sh);
        logic [63:0] dbl;
        dbl = {v, v} << sh;
        return dbl[63:32];
    endfunction

    // Mask from bit mb to bit me in big-endian numbering, wrapping when mb > me.
    function automatic logic [31:0] rot_mask(logic [4:0] mb, logic [4:0] me);
        int lo;
        int hi;
        lo = mb;
        hi = me;
        if (lo <= hi) begin
            return (32'hFFFF_FFFF >> (31 - (hi - lo))) << (31 - hi);
        end
        return (32'hFFFF_FFFF >> lo) | (32'hFFFF_FFFF << (31 - hi));
    endfunction

    // Executes one instruction against the tracked state and returns its result.
    function automatic t_exec_result execute_instr(logic [31:0] w, logic [31:0] a);
        logic [5:0]  op;
        logic [4:0]  rt;
        logic [4:0]  ra;
        logic [4:0]  rb;
        logic [9:0]  x10;
        logic [4:0]  x5;
        logic [31:0] uimm;
        logic [31:0] uimm_hi;
        logic [31:0] simm;
        logic [31:0] npc;
        logic [31:0] val;
        logic [31:0] m;
        logic [31:0] target;
        logic [4:0]  didx;
        logic        wr;
        logic        rec;
        logic        take;
        t_status     st;
        t_exec_result r;
        op      = w[31:26];
        rt      = w[25:21];
        ra      = w[20:16];
        rb      = w[15:11];
        x10     = w[10:1];
        x5      = w[5:1];
        uimm    = {16'h0000, w[15:0]};
        uimm_hi = {w[15:0], 16'h0000};
        simm    = {{16{w[15]}}, w[15:0]};
        npc     = a + 32'd4;
        val     = '0;
        didx    = '0;
        wr      = 1'b0;
        rec     = 1'b0;
        st      = ST_EXEC;
        case (op)
            OP_ADDI: begin
                didx = rt; val = (ra == 0 ? 32'd0 : gpr[ra]) + simm; wr = 1'b1;
            end
            OP_ADDIS: begin
                didx = rt; val = (ra == 0 ? 32'd0 : gpr[ra]) + uimm_hi; wr = 1'b1;
            end
            OP_ORI:   begin didx = ra; val = gpr[rt] | uimm;    wr = 1'b1; end
            OP_ORIS:  begin didx = ra; val = gpr[rt] | uimm_hi; wr = 1'b1; end
            OP_XORI:  begin didx = ra; val = gpr[rt] ^ uimm;    wr = 1'b1; end
            OP_XORIS: begin didx = ra; val = gpr[rt] ^ uimm_hi; wr = 1'b1; end
            OP_ANDI:  begin didx = ra; val = gpr[rt] & uimm;    wr = 1'b1; rec = 1'b1; end
            OP_ANDIS: begin didx = ra; val = gpr[rt] & uimm_hi; wr = 1'b1; rec = 1'b1; end
            OP_RLWIMI, OP_RLWINM: begin
                m   = rot_mask(w[10:6], w[5:1]);
                val = rot_left(gpr[rt], rb) & m;
                if (op == OP_RLWIMI) begin
                    val = val | (gpr[ra] & ~m);
                end
                didx = ra; wr = 1'b1; rec = w[0];
            end
            OP_B: begin
                target = {{6{w[25]}}, w[25:2], 2'b00};
                if (w[0]) begin
                    lr = a + 32'd4;
                end
                npc = w[1] ? target : a + target;
            end
            OP_BC: begin
                // BO sits in the rt slot and BI in the ra slot.
                target = {{16{w[15]}}, w[15:2], 2'b00};
                take   = 1'b1;
                if (w[0]) begin
                    lr = a + 32'd4;
                end
                if (!rt[2]) begin
                    ctr = ctr - 32'd1;
                    if ((ctr == 0) != rt[1]) begin
                        take = 1'b0;
                    end
                end
                if (take && !rt[4]) begin
                    if (cr[31 - int'(ra)] != rt[3]) begin
                        take = 1'b0;
                    end
                end
                if (take) begin
                    npc = w[1] ? target : a + target;
                end
            end
            default: begin
                if (op == OP_GRP31 && x10 == XO_ADD) begin
                    didx = rt; val = gpr[ra] + gpr[rb]; wr = 1'b1; rec = w[0];
                end else begin
                    st = classify_other(op, x10, x5);
                end
            end
        endcase
        if (wr) begin
            gpr[didx] = val;
            if (rec) begin
                cr[31] = val[31];
                cr[30] = !val[31] && (val != 0);
                cr[29] = (val == 0);
            end
        end
        r.next_pc     = npc;
        r.status      = st;
        r.reg_written = wr;
        r.dest_index  = wr ? didx : 5'd0;
        r.dest_value  = wr ? val : 32'd0;
        r.cr0_bits    = cr[31:28];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (gpr[i]) begin
                gpr[i] = '0;
            end
            cr = '0;
            lr = '0;
            ctr = '0;
            results_due.delete();
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (results_due.size() == 0) begin
                    report_mismatch("result with no instruction outstanding",
                                    result_ch.next_pc, 32'd0);
                end else begin
                    due = results_due.pop_front();
                    if (result_ch.next_pc !== due.next_pc) begin
                        report_mismatch("next_pc", result_ch.next_pc, due.next_pc);
                    end
                    if (result_ch.status !== due.status) begin
                        report_mismatch("status", 32'(result_ch.status), 32'(due.status));
                    end
                    if (result_ch.reg_written !== due.reg_written) begin
                        report_mismatch("reg_written", 32'(result_ch.reg_written),
                                        32'(due.reg_written));
                    end
                    if (result_ch.dest_index !== due.dest_index) begin
                        report_mismatch("dest_index", 32'(result_ch.dest_index),
                                        32'(due.dest_index));
                    end
                    if (result_ch.dest_value !== due.dest_value) begin
                        report_mismatch("dest_value", result_ch.dest_value, due.dest_value);
                    end
                    if (result_ch.cr0_bits !== due.cr0_bits) begin
                        report_mismatch("cr0_bits", 32'(result_ch.cr0_bits),
                                        32'(due.cr0_bits));
                    end
                end
                results_seen++;
            end
            if (instr_ch.valid && instr_ch.ready) begin
                results_due.push_back(execute_instr(instr_ch.instr_word, instr_ch.instr_addr));
            end
        end
        o_results_due = results_due.size();
    end

endmodule

/* bench/tb_ppc_integer_branch_execute_core.sv */
// Top of the execute core bench. It makes the clock, the reset and the
// instruction stream, drives the result ready with a stall pattern, and
// gives the verdict. All prediction and comparison live in the checker.
module tb_ppc_integer_branch_execute_core;
    import pibe_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int DRAIN_CYCLES  = 16;
    // The limit leaves a wide margin over the roughly 1830 items that are sent.
    localparam int CYCLE_LIMIT   = 400000;

    // Opcodes outside the package that the directed part names.
    localparam logic [5:0] OP_RESERVED0 = 6'd0;
    localparam logic [5:0] OP_SC        = 6'd17;
    localparam logic [5:0] OP_LWZ       = 6'd32;
    localparam logic [9:0] XO_DCBF      = 10'd86;
    localparam logic [9:0] XO_ADDO      = XO_ADD | 10'd512;

    // Branch option codes and CR0 bit indexes.
    localparam logic [4:0] BO_ALWAYS = 5'b10100;
    localparam logic [4:0] BO_DNZ    = 5'b10000;
    localparam logic [4:0] BO_DZ     = 5'b10010;
    localparam logic [4:0] BO_TRUE   = 5'b01100;
    localparam logic [4:0] CR0_LT    = 5'd0;
    localparam logic [4:0] CR0_EQ    = 5'd2;

    // Extended opcodes that land in each class of the grouped primaries:
    // add with and without overflow enable, cache and sync no-ops, memory
    // accesses, interpreter fallbacks and a few that are only valid in
    // another group.
    localparam logic [9:0] XO_PICKS [16] = '{
        10'd266, 10'd778, 10'd86,  10'd1014, 10'd150, 10'd535, 10'd662, 10'd339,
        10'd0,   10'd18,  10'd16,  10'd528,  10'd583, 10'd711, 10'd50,  10'd854
    };
    localparam logic [5:0] GROUP_OPS [5] = '{OP_GRP4, OP_GRP19, OP_GRP31, OP_GRP59, OP_GRP63};

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    pibe_instr_if  instr_ch ();
    pibe_result_if result_ch ();

    int mismatches;
    int results_due;
    int cycle_count = 0;
    int burst_left  = 0;
    int run_left    = 0;
    int stall_left  = 0;
    logic [31:0] pc = 32'h0000_1000;

    ppc_integer_branch_execute_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_instr  (instr_ch),
        .o_result (result_ch)
    );

    pibe_exec_checker exec_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .instr_ch      (instr_ch),
        .result_ch     (result_ch),
        .o_mismatches  (mismatches),
        .o_results_due (results_due)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // A hung handshake must not run forever.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // The receiver takes items for a run of cycles and then stalls for a
    // few. Some runs carry no stall at all, and now and then a long run
    // lets the pipeline stream at full rate.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            result_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            result_ch.ready <= 1'b1;
            if (run_left > 0) begin
                run_left <= run_left - 1;
            end else begin
                run_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(1, 40);
                stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
        end
    end

    // Instruction encoders for the D, X, M, I and B forms.
    function automatic logic [31:0] d_form(logic [5:0] op, logic [4:0] rt, logic [4:0] ra,
                                           logic [15:0] imm);
        return {op, rt, ra, imm};
    endfunction

    function automatic logic [31:0] x_form(logic [5:0] op, logic [4:0] rt, logic [4:0] ra,
                                           logic [4:0] rb, logic [9:0] xo, logic rc);
        return {op, rt, ra, rb, xo, rc};
    endfunction

    function automatic logic [31:0] m_form(logic [5:0] op, logic [4:0] rs, logic [4:0] ra,
                                           logic [4:0] sh, logic [4:0] mb, logic [4:0] me,
                                           logic rc);
        return {op, rs, ra, sh, mb, me, rc};
    endfunction

    function automatic logic [31:0] b_form(logic [25:0] offset, logic aa, logic lk);
        return {OP_B, offset[25:2], aa, lk};
    endfunction

    function automatic logic [31:0] bc_form(logic [4:0] bo, logic [4:0] bi,
                                            logic [15:0] offset, logic aa, logic lk);
        return {OP_BC, bo, bi, offset[15:2], aa, lk};
    endfunction

    // At least half of the register picks fall on r0..r3 so that results feed the
    // next instructions and the rA-is-zero form comes up often.
    function automatic logic [4:0] pick_reg();
        return $urandom_range(0, 1) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
    endfunction

    function automatic logic [15:0] pick_imm();
        case ($urandom_range(0, 11))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Sequential fetch with an occasional jump, including to either end of
    // the address space so that the PC increment wraps.
    function automatic logic [31:0] fetch_addr();
        logic [31:0] a;
        case ($urandom_range(0, 63))
            0: pc = 32'h0000_0000;
            1: pc = 32'hFFFF_FFFC;
            2, 3, 4: pc = $urandom & ~32'h3;
            default: ;
        endcase
        a = pc;
        pc = pc + 32'd4;
        return a;
    endfunction

    // Mostly executable instructions with random fields, then the grouped
    // primaries with extended opcodes from every class, then raw words.
    function automatic logic [31:0] random_instr();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) return d_form(OP_ADDI, pick_reg(), pick_reg(), pick_imm());
        if (pick < 15) return d_form(OP_ADDIS, pick_reg(), pick_reg(), pick_imm());
        if (pick < 22) return d_form(OP_ORI, pick_reg(), pick_reg(), pick_imm());
        if (pick < 26) return d_form(OP_ORIS, pick_reg(), pick_reg(), pick_imm());
        if (pick < 32) return d_form(OP_XORI, pick_reg(), pick_reg(), pick_imm());
        if (pick < 36) return d_form(OP_XORIS, pick_reg(), pick_reg(), pick_imm());
        if (pick < 42) return d_form(OP_ANDI, pick_reg(), pick_reg(), pick_imm());
        if (pick < 46) return d_form(OP_ANDIS, pick_reg(), pick_reg(), pick_imm());
        if (pick < 54) begin
            return m_form(OP_RLWINM, pick_reg(), pick_reg(), 5'($urandom), 5'($urandom),
                          5'($urandom), 1'($urandom));
        end
        if (pick < 60) begin
            return m_form(OP_RLWIMI, pick_reg(), pick_reg(), 5'($urandom), 5'($urandom),
                          5'($urandom), 1'($urandom));
        end
        if (pick < 68) begin
            return x_form(OP_GRP31, pick_reg(), pick_reg(), pick_reg(),
                          ($urandom_range(0, 7) == 0) ? XO_ADDO : XO_ADD, 1'($urandom));
        end
        if (pick < 74) return b_form(26'($urandom), 1'($urandom), 1'($urandom));
        if (pick < 84) begin
            return bc_form(5'($urandom), $urandom_range(0, 1) ? 5'($urandom_range(0, 3))
                                                             : 5'($urandom),
                           16'($urandom), 1'($urandom), 1'($urandom));
        end
        if (pick < 92) begin
            return x_form(GROUP_OPS[$urandom_range(0, 4)], 5'($urandom), 5'($urandom),
                          5'($urandom), $urandom_range(0, 1) ? XO_PICKS[$urandom_range(0, 15)]
                                                             : 10'($urandom),
                          1'($urandom));
        end
        return $urandom;
    endfunction

    // Sends one item. The sender works in bursts; between bursts valid
    // drops for a random gap, and some bursts follow with no gap at all.
    // Valid only falls at the start of a gap, so it never gets two
    // assignments in one time step.
    task automatic issue(input logic [31:0] word, input logic [31:0] addr);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
            if (gap > 0) begin
                instr_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        instr_ch.valid      <= 1'b1;
        instr_ch.instr_word <= word;
        instr_ch.instr_addr <= addr;
        do @(posedge i_clk); while (!instr_ch.ready);
    endtask

    initial begin
        instr_ch.valid      <= 1'b0;
        instr_ch.instr_word <= '0;
        instr_ch.instr_addr <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Immediate forms at their extremes. The first addi uses rA zero,
        // which means the value zero and not r0, and sits at address zero.
        issue(d_form(OP_ADDI, 5'd1, 5'd0, 16'hFFFF), 32'h0000_0000);
        issue(d_form(OP_ADDI, 5'd2, 5'd1, 16'h7FFF), fetch_addr());
        issue(d_form(OP_ADDIS, 5'd3, 5'd0, 16'h8000), fetch_addr());
        issue(d_form(OP_ADDIS, 5'd4, 5'd3, 16'hFFFF), fetch_addr());
        issue(d_form(OP_ORI, 5'd2, 5'd5, 16'h8000), fetch_addr());
        issue(d_form(OP_ORIS, 5'd1, 5'd6, 16'h0000), fetch_addr());
        issue(d_form(OP_XORI, 5'd1, 5'd7, 16'hFFFF), fetch_addr());
        issue(d_form(OP_XORIS, 5'd4, 5'd8, 16'h8000), fetch_addr());

        // The AND forms always record: zero, positive, then negative.
        issue(d_form(OP_ANDI, 5'd1, 5'd9, 16'h0000), fetch_addr());
        issue(d_form(OP_ANDI, 5'd1, 5'd10, 16'h7FFF), fetch_addr());
        issue(d_form(OP_ANDIS, 5'd1, 5'd11, 16'h8000), fetch_addr());

        // Rotates: a one-bit mask with record, then a mask that wraps around.
        issue(m_form(OP_RLWINM, 5'd3, 5'd12, 5'd1, 5'd31, 5'd31, 1'b1), fetch_addr());
        issue(m_form(OP_RLWIMI, 5'd1, 5'd12, 5'd31, 5'd28, 5'd3, 1'b0), fetch_addr());

        // add. that overflows to zero and sets EQ; with overflow enable set
        // the same word is not an add and comes back illegal.
        issue(x_form(OP_GRP31, 5'd14, 5'd3, 5'd3, XO_ADD, 1'b1), fetch_addr());
        issue(x_form(OP_GRP31, 5'd15, 5'd3, 5'd3, XO_ADDO, 1'b0), fetch_addr());

        // Unconditional branches: most negative relative offset with link,
        // and the largest absolute target from the top of the address space.
        issue(b_form(26'h200_0000, 1'b0, 1'b1), 32'h0000_0100);
        issue(b_form(26'h1FF_FFFC, 1'b1, 1'b0), 32'hFFFF_FFFC);

        // Conditional branches. CTR starts at zero, so the first decrement
        // wraps it; a not-taken branch still writes the link register.
        issue(bc_form(BO_ALWAYS, 5'd0, 16'h8000, 1'b1, 1'b1), fetch_addr());
        issue(bc_form(BO_DNZ, 5'd7, 16'h7FFC, 1'b0, 1'b0), fetch_addr());
        issue(bc_form(BO_DZ, 5'd0, 16'h0040, 1'b0, 1'b1), fetch_addr());
        issue(bc_form(BO_TRUE, CR0_EQ, 16'hFFF0, 1'b0, 1'b0), fetch_addr());
        issue(bc_form(BO_TRUE, CR0_LT, 16'h0010, 1'b0, 1'b0), 32'h0000_0003);

        // Words the core only classifies: cache no-op, sync, memory access,
        // interpreter fallback and an undefined primary opcode.
        issue(x_form(OP_GRP31, 5'd0, 5'd1, 5'd2, XO_DCBF, 1'b0), fetch_addr());
        issue(x_form(OP_GRP19, 5'd0, 5'd0, 5'd0, XO_ISYNC, 1'b0), fetch_addr());
        issue(d_form(OP_LWZ, 5'd3, 5'd1, 16'h0008), fetch_addr());
        issue(d_form(OP_SC, 5'd0, 5'd0, 16'h0002), fetch_addr());
        issue(d_form(OP_RESERVED0, 5'd31, 5'd31, 16'hFFFF), fetch_addr());

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            issue(random_instr(), fetch_addr());
        end
        instr_ch.valid <= 1'b0;

        // Let the last accepted item reach the checker, wait for every
        // result, then give the core a few more cycles to show anything
        // spurious.
        @(posedge i_clk);
        while (results_due != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/pibe_pkg.sv
hw/rtl/pibe_instr_if.sv
hw/rtl/pibe_result_if.sv
hw/rtl/pibe_front.sv
hw/rtl/pibe_queue.sv
hw/rtl/pibe_back.sv
hw/rtl/ppc_integer_branch_execute_core.sv
bench/pibe_exec_checker.sv
bench/tb_ppc_integer_branch_execute_core.sv
